/* sv/utf8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

    // Codepoint limits and special values.
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] MAX_CP         = 21'h10FFFF;
    localparam logic [20:0] SURR_LO        = 21'h00D800;
    localparam logic [20:0] SURR_HI        = 21'h00DFFF;
    localparam logic [20:0] MIN_CP_LEN2    = 21'h000080;
    localparam logic [20:0] MIN_CP_LEN3    = 21'h000800;
    localparam logic [20:0] MIN_CP_LEN4    = 21'h010000;

    // Byte classes.
    localparam logic [7:0] ASCII_HI  = 8'h7F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF7;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // Register indexes on the configuration port.
    localparam logic REG_STRICT   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // Result queue geometry.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // Status codes on the end-of-message word.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_SHORT   = 2'd2
    } status_t;

    // One result word.
    typedef struct packed {
        logic [20:0] codepoint;
        logic        is_status;
        status_t     status;
        logic [15:0] output_count;
        logic        last_of_run;
    } result_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]  cont_left;
        logic [2:0]  seq_len;
        logic [20:0] partial;
        logic        error_seen;
        logic        too_short;
        logic [15:0] emitted;
        logic        halted;
    } dec_state_t;

    // Configuration seen by the decoder.
    typedef struct packed {
        logic        strict_mode;
        logic [15:0] output_capacity;
    } cfg_t;

endpackage

/* sv/utf8sd_if.sv */
// Valid/ready channel interfaces for input bytes and result words.
interface utf8sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] bytes_left;

    modport source (output valid, output data_byte, output bytes_left, input ready);
    modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface utf8sd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] codepoint;
    logic        is_status;
    logic [1:0]  status;
    logic [15:0] output_count;
    logic        last_of_run;

    modport source (output valid, output codepoint, output is_status, output status,
                    output output_count, output last_of_run, input ready);
    modport sink   (input valid, input codepoint, input is_status, input status,
                    input output_count, input last_of_run, output ready);
endinterface

/* sv/utf8sd_dec.sv */
// Byte decoder: state registers and the single-pass next-state and result logic.
module utf8sd_dec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  utf8sd_pkg::cfg_t              cfg,
    input  logic                          in_fire,
    input  logic [7:0]                    data_byte,
    input  logic [2:0]                    bytes_left,
    output utf8sd_pkg::result_t [2:0]     results,
    output logic [1:0]                    result_cnt
);

    utf8sd_pkg::dec_state_t state_reg;
    utf8sd_pkg::dec_state_t state_next;
    utf8sd_pkg::result_t [2:0] r;
    logic [1:0]  n;
    logic [2:0]  room;
    logic        last;
    logic        start;
    logic        lead_ok;
    logic [2:0]  len;
    logic [20:0] lead_bits;
    logic [20:0] cp;
    logic [20:0] minv;

    // Room left in the message; zero counts as the last byte.
    always_comb
    begin
        unique case (bytes_left)
            3'd0, 3'd1: room = 3'd1;
            3'd2:       room = 3'd2;
            3'd3:       room = 3'd3;
            default:    room = 3'd4;
        endcase
        last = (bytes_left <= 3'd1);
    end

    // Lead byte classification.
    always_comb
    begin
        lead_ok   = 1'b1;
        len       = 3'd1;
        lead_bits = {13'd0, data_byte};
        if (data_byte <= utf8sd_pkg::ASCII_HI)
        begin
            len       = 3'd1;
            lead_bits = {13'd0, data_byte};
        end
        else if (data_byte >= utf8sd_pkg::LEAD2_LO && data_byte <= utf8sd_pkg::LEAD2_HI)
        begin
            len       = 3'd2;
            lead_bits = {16'd0, data_byte[4:0]};
        end
        else if (data_byte >= utf8sd_pkg::LEAD3_LO && data_byte <= utf8sd_pkg::LEAD3_HI)
        begin
            len       = 3'd3;
            lead_bits = {17'd0, data_byte[3:0]};
        end
        else if (data_byte >= utf8sd_pkg::LEAD4_LO && data_byte <= utf8sd_pkg::LEAD4_HI)
        begin
            len       = 3'd4;
            lead_bits = {18'd0, data_byte[2:0]};
        end
        else
        begin
            lead_ok = 1'b0;
        end
    end

    // Next state and up to three result words for the current byte.
    always_comb
    begin
        state_next = state_reg;
        r          = '0;
        n          = 2'd0;
        start      = 1'b0;
        cp         = state_reg.partial;
        minv       = utf8sd_pkg::MIN_CP_LEN4;

        if (!state_next.halted)
        begin
            if (state_next.cont_left != 2'd0)
            begin
                if (data_byte >= utf8sd_pkg::CONT_LO && data_byte <= utf8sd_pkg::CONT_HI)
                begin
                    state_next.partial   = {state_next.partial[14:0],
                                            data_byte[5:0] & utf8sd_pkg::CONT_MASK[5:0]};
                    state_next.cont_left = state_next.cont_left - 2'd1;
                    if (state_next.cont_left == 2'd0)
                    begin
                        // Sequence complete: range checks.
                        cp = state_next.partial;
                        if (state_next.seq_len == 3'd2)
                            minv = utf8sd_pkg::MIN_CP_LEN2;
                        else if (state_next.seq_len == 3'd3)
                            minv = utf8sd_pkg::MIN_CP_LEN3;
                        state_next.seq_len = 3'd0;
                        state_next.partial = '0;
                        if (cp < minv || cp > utf8sd_pkg::MAX_CP ||
                            (cp >= utf8sd_pkg::SURR_LO && cp <= utf8sd_pkg::SURR_HI))
                        begin
                            state_next.error_seen = 1'b1;
                            if (cfg.strict_mode)
                                state_next.halted = 1'b1;
                            else
                            begin
                                r[n].codepoint     = utf8sd_pkg::REPLACEMENT_CP;
                                n                  = n + 2'd1;
                                state_next.emitted = state_next.emitted + 16'd1;
                            end
                        end
                        else
                        begin
                            r[n].codepoint     = cp;
                            n                  = n + 2'd1;
                            state_next.emitted = state_next.emitted + 16'd1;
                        end
                    end
                end
                else
                begin
                    // Interrupted sequence: invalid, then the byte acts as a lead.
                    state_next.cont_left  = 2'd0;
                    state_next.seq_len    = 3'd0;
                    state_next.partial    = '0;
                    state_next.error_seen = 1'b1;
                    if (cfg.strict_mode)
                        state_next.halted = 1'b1;
                    else
                    begin
                        r[n].codepoint     = utf8sd_pkg::REPLACEMENT_CP;
                        n                  = n + 2'd1;
                        state_next.emitted = state_next.emitted + 16'd1;
                        start              = 1'b1;
                    end
                end
            end
            else
            begin
                start = 1'b1;
            end

            // Start of a new sequence.
            if (start)
            begin
                if (state_next.emitted >= cfg.output_capacity)
                    state_next.halted = 1'b1;
                else if (!lead_ok)
                begin
                    state_next.error_seen = 1'b1;
                    if (cfg.strict_mode)
                        state_next.halted = 1'b1;
                    else
                    begin
                        r[n].codepoint     = utf8sd_pkg::REPLACEMENT_CP;
                        n                  = n + 2'd1;
                        state_next.emitted = state_next.emitted + 16'd1;
                    end
                end
                else if (len > room)
                begin
                    state_next.too_short = 1'b1;
                    state_next.halted    = 1'b1;
                end
                else if (len == 3'd1)
                begin
                    r[n].codepoint     = lead_bits;
                    n                  = n + 2'd1;
                    state_next.emitted = state_next.emitted + 16'd1;
                end
                else
                begin
                    state_next.partial   = lead_bits;
                    state_next.seq_len   = len;
                    state_next.cont_left = len[1:0] - 2'd1;
                end
            end
        end

        // Last byte of the message: status word and a fresh start.
        if (last)
        begin
            if (!state_next.halted && state_next.cont_left != 2'd0)
                state_next.too_short = 1'b1;
            r[n].is_status    = 1'b1;
            r[n].output_count = state_next.emitted;
            if (state_next.too_short)
                r[n].status = utf8sd_pkg::STATUS_SHORT;
            else if (state_next.error_seen)
                r[n].status = utf8sd_pkg::STATUS_INVALID;
            else
                r[n].status = utf8sd_pkg::STATUS_OK;
            n          = n + 2'd1;
            state_next = '0;
        end

        // Flag the final word produced by this byte.
        if (n != 2'd0)
            r[n - 2'd1].last_of_run = 1'b1;
    end

    assign results    = r;
    assign result_cnt = in_fire ? n : 2'd0;

    // Decoder state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_fire)
            state_reg <= state_next;
    end

endmodule

/* sv/utf8sd_rq.sv */
// Result queue: takes up to three words per cycle, hands out one per cycle while out_ready is high.
module utf8sd_rq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  utf8sd_pkg::result_t [2:0]     push_items,
    input  logic [1:0]                    push_cnt,
    output logic                          can_accept,
    output logic                          out_valid,
    input  logic                          out_ready,
    output utf8sd_pkg::result_t           out_item
);

    utf8sd_pkg::result_t entry_reg [utf8sd_pkg::QUEUE_DEPTH];
    logic [utf8sd_pkg::QPTR_W-1:0] head_reg;
    logic [utf8sd_pkg::QPTR_W-1:0] head_next;
    logic [utf8sd_pkg::QCNT_W-1:0] count_reg;
    logic [utf8sd_pkg::QCNT_W-1:0] count_next;
    logic [utf8sd_pkg::QPTR_W-1:0] tail;
    logic                          pop;

    // Room for three more words whatever the output side does.
    assign can_accept = (count_reg <= utf8sd_pkg::QCNT_W'(1));
    assign out_valid  = (count_reg != '0);
    assign out_item   = entry_reg[head_reg];
    assign pop        = out_valid & out_ready;
    assign tail       = head_reg + count_reg[utf8sd_pkg::QPTR_W-1:0];

    // Pointer and fill count update.
    always_comb
    begin
        head_next  = head_reg + utf8sd_pkg::QPTR_W'(pop);
        count_next = count_reg + utf8sd_pkg::QCNT_W'(push_cnt)
                     - utf8sd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Word storage, written at the tail.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push_cnt)
                entry_reg[tail + utf8sd_pkg::QPTR_W'(i)] <= push_items[i];
        end
    end

endmodule

/* sv/utf8_stream_decoder.sv */
// A byte's result words are written into the result queue at the clock edge that accepts the byte.
// Throughput: one byte per cycle while each byte yields at most one word and the output is
// ready; the queue drains one word per cycle, so bytes with two or three words slow intake.
// Input is taken whenever the four-word result queue holds at most one word.
// Reset (rst_n low, asynchronous) clears the decoder state and the queue,
// and sets strict_mode to 0 and output_capacity to 65535.
module utf8_stream_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    utf8sd_in_if.sink            in_ch,
    utf8sd_out_if.source         out_ch
);

    utf8sd_pkg::cfg_t              cfg_reg;
    utf8sd_pkg::result_t [2:0]     results;
    utf8sd_pkg::result_t           out_item;
    logic [1:0]                    result_cnt;
    logic                          can_accept;
    logic                          in_fire;
    logic                          cfg_write;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strict_mode     <= 1'b0;
            cfg_reg.output_capacity <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                utf8sd_pkg::REG_STRICT:   cfg_reg.strict_mode     <= pwdata[0];
                utf8sd_pkg::REG_CAPACITY: cfg_reg.output_capacity <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            utf8sd_pkg::REG_STRICT:   prdata = {31'd0, cfg_reg.strict_mode};
            utf8sd_pkg::REG_CAPACITY: prdata = {16'd0, cfg_reg.output_capacity};
        endcase
    end

    // Input handshake.
    assign in_ch.ready = can_accept;
    assign in_fire     = in_ch.valid & can_accept;

    utf8sd_dec u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_fire    (in_fire),
        .data_byte  (in_ch.data_byte),
        .bytes_left (in_ch.bytes_left),
        .results    (results),
        .result_cnt (result_cnt)
    );

    utf8sd_rq u_rq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_items (results),
        .push_cnt   (result_cnt),
        .can_accept (can_accept),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_item   (out_item)
    );

    // Output word fields.
    assign out_ch.codepoint    = out_item.codepoint;
    assign out_ch.is_status    = out_item.is_status;
    assign out_ch.status       = out_item.status;
    assign out_ch.output_count = out_item.output_count;
    assign out_ch.last_of_run  = out_item.last_of_run;

endmodule

/* bench/utf8_stream_decoder_tb.sv */
// Self-checking testbench for the UTF-8 stream decoder: directed table, random messages.
module utf8_stream_decoder_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_BYTES = 38;
    localparam utf8sd_pkg::result_t NO_WORD = '0;

    // One row of the directed table. A row with n_fixed above zero carries its
    // expected words; the other rows are checked against the decoder model.
    typedef struct packed {
        logic [7:0]          data;
        logic [2:0]          left;
        logic [1:0]          n_fixed;
        utf8sd_pkg::result_t w0;
        utf8sd_pkg::result_t w1;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    utf8sd_in_if  in_ch ();
    utf8sd_out_if out_ch ();

    utf8_stream_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Decoder model: configuration and per-message state.
    logic                 dec_strict;
    logic [15:0]          dec_capacity;
    logic [1:0]           dec_cont;
    logic [2:0]           dec_len;
    logic [20:0]          dec_bits;
    bit                   dec_err;
    bit                   dec_short;
    bit                   dec_halt;
    logic [15:0]          dec_count;
    utf8sd_pkg::result_t  byte_words[$];

    // Words the block still owes, oldest first.
    utf8sd_pkg::result_t  pending_words[$];

    int          fail_cnt;
    int          bytes_sent;
    int          live_bytes;
    int          messages_sent;
    int          words_checked;
    int          status_tally[3];
    bit          idle_on;
    bit          hold_req;

    stim_row_t   dir_rows [0:22];

    function automatic utf8sd_pkg::result_t codepoint_word(input logic [20:0] cp,
                                                           input logic last);
        utf8sd_pkg::result_t w;
        w = '0;
        w.codepoint = cp;
        w.last_of_run = last;
        return w;
    endfunction

    // A status word always closes the words of its byte.
    function automatic utf8sd_pkg::result_t status_word(input utf8sd_pkg::status_t code,
                                                        input logic [15:0] cnt);
        utf8sd_pkg::result_t w;
        w = '0;
        w.is_status = 1'b1;
        w.status = code;
        w.output_count = cnt;
        w.last_of_run = 1'b1;
        return w;
    endfunction

    function automatic void emit_char(input logic [20:0] cp);
        byte_words.push_back(codepoint_word(cp, 1'b0));
        dec_count = dec_count + 16'd1;
    endfunction

    function automatic void reject_seq();
        dec_err = 1'b1;
        if (dec_strict)
            dec_halt = 1'b1;
        else
            emit_char(utf8sd_pkg::REPLACEMENT_CP);
    endfunction

    // Classify a lead byte and open its sequence.
    function automatic void begin_seq(input logic [7:0] b, input int room);
        int         len;
        logic [7:0] base;
        if (dec_count >= dec_capacity)
        begin
            dec_halt = 1'b1;
            return;
        end
        if (b <= utf8sd_pkg::ASCII_HI)
        begin
            len = 1;
            base = 8'h00;
        end
        else if (b >= utf8sd_pkg::LEAD2_LO && b <= utf8sd_pkg::LEAD2_HI)
        begin
            len = 2;
            base = utf8sd_pkg::LEAD2_LO;
        end
        else if (b >= utf8sd_pkg::LEAD3_LO && b <= utf8sd_pkg::LEAD3_HI)
        begin
            len = 3;
            base = utf8sd_pkg::LEAD3_LO;
        end
        else if (b >= utf8sd_pkg::LEAD4_LO && b <= utf8sd_pkg::LEAD4_HI)
        begin
            len = 4;
            base = utf8sd_pkg::LEAD4_LO;
        end
        else
        begin
            reject_seq();
            return;
        end
        if (len > room)
        begin
            dec_short = 1'b1;
            dec_halt = 1'b1;
            return;
        end
        if (len == 1)
        begin
            emit_char({13'd0, b});
            return;
        end
        dec_bits = {13'd0, b - base};
        dec_len = 3'(len);
        dec_cont = 2'(len - 1);
    endfunction

    // Range checks on a completed sequence.
    function automatic void end_seq();
        logic [20:0] cp;
        logic [20:0] minv;
        cp = dec_bits;
        case (dec_len)
            3'd2:    minv = utf8sd_pkg::MIN_CP_LEN2;
            3'd3:    minv = utf8sd_pkg::MIN_CP_LEN3;
            default: minv = utf8sd_pkg::MIN_CP_LEN4;
        endcase
        dec_len = '0;
        dec_bits = '0;
        if (cp < minv || (cp >= utf8sd_pkg::SURR_LO && cp <= utf8sd_pkg::SURR_HI) ||
            cp > utf8sd_pkg::MAX_CP)
            reject_seq();
        else
            emit_char(cp);
    endfunction

    // Work out the words of one accepted byte; returns 0 when the byte is ignored.
    function automatic bit decode_byte(input logic [7:0] b, input logic [2:0] bl);
        bit                  msg_end;
        bit                  worked;
        int                  room;
        utf8sd_pkg::status_t code;
        msg_end = (bl <= 3'd1);
        room = (bl == 3'd0) ? 1 : ((bl > 3'd4) ? 4 : int'(bl));
        worked = !dec_halt || msg_end;
        byte_words.delete();
        if (!dec_halt)
        begin
            if (dec_cont > 2'd0)
            begin
                if (b >= utf8sd_pkg::CONT_LO && b <= utf8sd_pkg::CONT_HI)
                begin
                    dec_bits = {dec_bits[14:0], b[5:0]};
                    dec_cont = dec_cont - 2'd1;
                    if (dec_cont == 2'd0)
                        end_seq();
                end
                else
                begin
                    // Interrupted sequence: drop it, then treat this byte as a lead.
                    dec_cont = '0;
                    dec_len = '0;
                    dec_bits = '0;
                    reject_seq();
                    if (!dec_halt)
                        begin_seq(b, room);
                end
            end
            else
            begin
                begin_seq(b, room);
            end
        end
        if (msg_end)
        begin
            if (!dec_halt && dec_cont > 2'd0)
                dec_short = 1'b1;
            code = dec_short ? utf8sd_pkg::STATUS_SHORT :
                   (dec_err ? utf8sd_pkg::STATUS_INVALID : utf8sd_pkg::STATUS_OK);
            byte_words.push_back(status_word(code, dec_count));
            dec_cont = '0;
            dec_len = '0;
            dec_bits = '0;
            dec_err = 1'b0;
            dec_short = 1'b0;
            dec_count = '0;
            dec_halt = 1'b0;
        end
        if (byte_words.size() > 0)
            byte_words[byte_words.size() - 1].last_of_run = 1'b1;
        return worked;
    endfunction

    // Append the UTF-8 form of cp at the given length, overlong or out of range as given.
    function automatic void encode_cp(ref logic [7:0] q[$], input logic [20:0] cp,
                                      input int len);
        case (len)
            1: q.push_back(cp[7:0]);
            2:
            begin
                q.push_back({3'b110, cp[10:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                q.push_back({4'b1110, cp[15:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                q.push_back({5'b11110, cp[20:18]});
                q.push_back({2'b10, cp[17:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Offer one byte until it is taken, then queue its expected words.
    task automatic send_byte(input logic [7:0] d, input logic [2:0] l,
                             input logic [1:0] n_fixed,
                             input utf8sd_pkg::result_t w0, input utf8sd_pkg::result_t w1);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.bytes_left <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
        if (decode_byte(d, l))
            live_bytes++;
        if (n_fixed == 2'd0)
        begin
            foreach (byte_words[i])
                pending_words.push_back(byte_words[i]);
        end
        else
        begin
            pending_words.push_back(w0);
            if (n_fixed == 2'd2)
                pending_words.push_back(w1);
        end
    endtask

    // Build one random message: mostly well-formed characters, some broken ones.
    task automatic send_message();
        logic [7:0]  msg[$];
        logic [20:0] cp;
        logic [20:0] minv;
        logic [2:0]  left;
        int          kind;
        int          len;
        int          rem;
        repeat ($urandom_range(1, 6))
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1: cp = 21'($urandom_range(0, 'h7F));
                    2: cp = 21'($urandom_range('h80, 'h7FF));
                    3:
                    begin
                        cp = 21'($urandom_range('h800, 'hFFFF));
                        if (cp >= utf8sd_pkg::SURR_LO && cp <= utf8sd_pkg::SURR_HI)
                            cp = cp ^ 21'h2000;
                    end
                    default: cp = 21'($urandom_range('h10000, 'h10FFFF));
                endcase
                encode_cp(msg, cp, len);
            end
            else if (kind < 70)
            begin
                // Overlong, surrogate or beyond the top of the code space.
                case ($urandom_range(0, 2))
                    0:
                    begin
                        len = $urandom_range(2, 4);
                        minv = (len == 2) ? utf8sd_pkg::MIN_CP_LEN2 :
                               ((len == 3) ? utf8sd_pkg::MIN_CP_LEN3 :
                                utf8sd_pkg::MIN_CP_LEN4);
                        cp = 21'($urandom_range(0, minv - 1));
                    end
                    1:
                    begin
                        len = 3;
                        cp = 21'($urandom_range(utf8sd_pkg::SURR_LO, utf8sd_pkg::SURR_HI));
                    end
                    default:
                    begin
                        len = 4;
                        cp = 21'($urandom_range('h110000, 'h1FFFFF));
                    end
                endcase
                encode_cp(msg, cp, len);
            end
            else if (kind < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                    msg.push_back(8'($urandom_range(utf8sd_pkg::CONT_LO, utf8sd_pkg::CONT_HI)));
                else
                    msg.push_back(8'($urandom_range('hF8, 'hFF)));
            end
            else if (kind < 90)
            begin
                // Truncated sequence: a lead followed by too few continuations.
                len = $urandom_range(2, 4);
                cp = (len == 2) ? 21'h0000E9 : ((len == 3) ? 21'h0020AC : 21'h01F600);
                encode_cp(msg, cp, len);
                repeat ($urandom_range(1, len - 1)) void'(msg.pop_back());
            end
            else
            begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end
        messages_sent++;
        foreach (msg[i])
        begin
            rem = msg.size() - i;
            left = (rem > 4) ? 3'd4 : 3'(rem);
            if (i < msg.size() - 1 && $urandom_range(0, 24) == 0)
                left = 3'($urandom_range(0, 7));
            send_byte(msg[i], left, 2'd0, NO_WORD, NO_WORD);
        end
    endtask

    // Let the block settle: drop the input and wait until all words are back.
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == utf8sd_pkg::REG_STRICT)
            dec_strict = value[0];
        else
            dec_capacity = value[15:0];
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stimulus: reset, directed table, then random phases under several settings.
    initial
    begin : stimulus
        bit          strict_set [5] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
        logic [15:0] cap_set [5]    = '{16'd65535, 16'd0, 16'd3, 16'd2, 16'd65535};
        int          start;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.bytes_left = 3'd1;
        idle_on = 1'b1;
        hold_req = 1'b0;
        fail_cnt = 0;
        dec_strict = 1'b0;
        dec_capacity = 16'd65535;
        dec_cont = '0;
        dec_len = '0;
        dec_bits = '0;
        dec_err = 1'b0;
        dec_short = 1'b0;
        dec_halt = 1'b0;
        dec_count = '0;

        dir_rows = '{
            // Top of ASCII, a lone continuation byte, and a lead with no room.
            '{8'h7F, 3'd1, 2'd2, codepoint_word(21'h7F, 1'b0),
              status_word(utf8sd_pkg::STATUS_OK, 16'd1)},
            '{8'h80, 3'd1, 2'd2, codepoint_word(utf8sd_pkg::REPLACEMENT_CP, 1'b0),
              status_word(utf8sd_pkg::STATUS_INVALID, 16'd1)},
            '{8'hC2, 3'd1, 2'd1, status_word(utf8sd_pkg::STATUS_SHORT, 16'd0), NO_WORD},
            // Well-formed two and three byte characters.
            '{8'hC2, 3'd2, 2'd0, NO_WORD, NO_WORD},
            '{8'hA9, 3'd1, 2'd0, NO_WORD, NO_WORD},
            '{8'hE2, 3'd3, 2'd0, NO_WORD, NO_WORD},
            '{8'h82, 3'd2, 2'd0, NO_WORD, NO_WORD},
            '{8'hAC, 3'd1, 2'd0, NO_WORD, NO_WORD},
            // Highest legal codepoint.
            '{8'hF4, 3'd4, 2'd0, NO_WORD, NO_WORD},
            '{8'h8F, 3'd3, 2'd0, NO_WORD, NO_WORD},
            '{8'hBF, 3'd2, 2'd0, NO_WORD, NO_WORD},
            '{8'hBF, 3'd1, 2'd2, codepoint_word(utf8sd_pkg::MAX_CP, 1'b0),
              status_word(utf8sd_pkg::STATUS_OK, 16'd1)},
            // Overlong form, then a surrogate.
            '{8'hC0, 3'd2, 2'd0, NO_WORD, NO_WORD},
            '{8'h80, 3'd1, 2'd0, NO_WORD, NO_WORD},
            '{8'hED, 3'd3, 2'd0, NO_WORD, NO_WORD},
            '{8'hA0, 3'd2, 2'd0, NO_WORD, NO_WORD},
            '{8'h80, 3'd1, 2'd0, NO_WORD, NO_WORD},
            // Sequence cut by a plain byte: three words from one byte.
            '{8'hC3, 3'd2, 2'd0, NO_WORD, NO_WORD},
            '{8'h41, 3'd1, 2'd0, NO_WORD, NO_WORD},
            // Message ends inside an open sequence.
            '{8'hE0, 3'd4, 2'd0, NO_WORD, NO_WORD},
            '{8'h80, 3'd1, 2'd0, NO_WORD, NO_WORD},
            // Bad lead with a count above four, then a zero count on the last byte.
            '{8'hFF, 3'd7, 2'd1, codepoint_word(utf8sd_pkg::REPLACEMENT_CP, 1'b1), NO_WORD},
            '{8'h00, 3'd0, 2'd2, codepoint_word(21'h0, 1'b0),
              status_word(utf8sd_pkg::STATUS_INVALID, 16'd2)}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].left, dir_rows[i].n_fixed,
                      dir_rows[i].w0, dir_rows[i].w1);
        wait_drain();

        // Random phases; the first one also holds the output off for a long stretch.
        for (int ph = 0; ph < 5; ph++)
        begin
            apb_write(utf8sd_pkg::REG_STRICT, {31'd0, strict_set[ph]});
            apb_write(utf8sd_pkg::REG_CAPACITY, {16'd0, cap_set[ph]});
            if (ph == 0)
                hold_req = 1'b1;
            if (ph == 4)
                idle_on = 1'b0;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_message();
            wait_drain();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d bytes (%0d decoded while active, %0d random messages).",
                 bytes_sent, live_bytes, messages_sent);
        $display("Checked %0d words: %0d ok, %0d invalid, %0d too short; strict on/off.",
                 words_checked, status_tally[0], status_tally[1], status_tally[2]);
        if (fail_cnt == 0)
            $display("utf8_stream_decoder: match");
        else
            $display("utf8_stream_decoder: mismatch");
        $finish;
    end

    // Output side: random stalls, one long hold-off, and the word-by-word check.
    initial
    begin : result_sink
        utf8sd_pkg::result_t got;
        utf8sd_pkg::result_t want;
        int                  hold_left;
        int                  stall_left;
        hold_left = 0;
        stall_left = 0;
        words_checked = 0;
        status_tally = '{0, 0, 0};
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.codepoint = out_ch.codepoint;
                got.is_status = out_ch.is_status;
                got.status = utf8sd_pkg::status_t'(out_ch.status);
                got.output_count = out_ch.output_count;
                got.last_of_run = out_ch.last_of_run;
                words_checked++;
                if (got.is_status && got.status <= utf8sd_pkg::STATUS_SHORT)
                    status_tally[got.status]++;
                if (pending_words.size() == 0)
                begin
                    $error("unexpected result word: codepoint %0h is_status %0b",
                           got.codepoint, got.is_status);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got.codepoint !== want.codepoint)
                    begin
                        $error("codepoint: expected %0h, got %0h",
                               want.codepoint, got.codepoint);
                        fail_cnt++;
                    end
                    if (got.is_status !== want.is_status)
                    begin
                        $error("is_status: expected %0b, got %0b",
                               want.is_status, got.is_status);
                        fail_cnt++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_cnt++;
                    end
                    if (got.output_count !== want.output_count)
                    begin
                        $error("output_count: expected %0d, got %0d",
                               want.output_count, got.output_count);
                        fail_cnt++;
                    end
                    if (got.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, got.last_of_run);
                        fail_cnt++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
        $display("utf8_stream_decoder: mismatch");
        $finish;
    end

endmodule
